// File: hdl/clbr_pkg.sv
// Shared types, constants and the control-store program for the LCD refresh core.
package clbr_pkg;

  localparam int CHARS_DEF = 16;
  localparam int LINES_DEF = 2;

  localparam logic [7:0] DDRAM_SET  = 8'h80;
  localparam logic [7:0] ROW_STRIDE = 8'h40;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [5:0] INSTR_WAIT = 6'd41;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_SETCUR = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  typedef logic [3:0] step_t;

  localparam step_t STEP_FETCH  = 4'd0;
  localparam step_t STEP_WRITE  = 4'd1;
  localparam step_t STEP_SETCUR = 4'd2;
  localparam step_t STEP_CLEAR  = 4'd3;
  localparam step_t STEP_TICK   = 4'd4;
  localparam step_t STEP_AHI    = 4'd5;
  localparam step_t STEP_ALO    = 4'd6;
  localparam step_t STEP_DHI    = 4'd7;
  localparam step_t STEP_DLO    = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_SETCUR,
    OP_CLEAR,
    OP_TICK
  } op_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ADDR_HI,
    EM_ADDR_LO,
    EM_DATA_HI,
    EM_DATA_LO
  } emit_t;

  typedef enum logic [1:0] {
    C_GOTO,
    C_ACCEPT,
    C_SCAN,
    C_OUT
  } cond_t;

  typedef struct packed {
    logic  in_rdy;
    op_t   op;
    emit_t emit;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] func;
    logic       scan_end;
    logic       row_start;
    logic       out_free;
  } sts_t;

  // The control store. Fetch dispatches on the function code: the four
  // handlers sit at target + func.
  function automatic ctl_t ucode(input step_t step);
    ctl_t w;
    w = '{in_rdy: 1'b0, op: OP_NONE, emit: EM_NONE, cond: C_GOTO, target: STEP_FETCH};
    case (step)
      STEP_FETCH: begin
        w.in_rdy = 1'b1;
        w.cond   = C_ACCEPT;
        w.target = STEP_WRITE;
      end
      STEP_WRITE:  w.op = OP_WRITE;
      STEP_SETCUR: w.op = OP_SETCUR;
      STEP_CLEAR:  w.op = OP_CLEAR;
      STEP_TICK: begin
        w.op     = OP_TICK;
        w.cond   = C_SCAN;
        w.target = STEP_DHI;
      end
      STEP_AHI: begin
        w.emit   = EM_ADDR_HI;
        w.cond   = C_OUT;
        w.target = STEP_ALO;
      end
      STEP_ALO: begin
        w.emit   = EM_ADDR_LO;
        w.cond   = C_OUT;
        w.target = STEP_DHI;
      end
      STEP_DHI: begin
        w.emit   = EM_DATA_HI;
        w.cond   = C_OUT;
        w.target = STEP_DLO;
      end
      STEP_DLO: begin
        w.emit   = EM_DATA_LO;
        w.cond   = C_OUT;
        w.target = STEP_FETCH;
      end
      default: w.target = STEP_FETCH;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/char_lcd_buffer_refresh_core.sv
// Top level: frame buffer datapath of the character LCD refresh core.
//
// The core holds a LINES x CHARS character frame buffer and a write cursor and
// turns each refresh tick into 4-bit HD44780 bus transactions (a set-address
// instruction at the start of each row, then the character, high nibble
// first). A small microprogram steps one control word per clock while no emit
// step waits on out_ready: write char, set cursor and clear buffer go straight
// back to fetch, a refresh tick emits the address nibbles only at a row start,
// then the data nibbles, and the wrap tick emits nothing and restarts the scan. The
// one-deep output register lets the next item be accepted while the final
// nibble of a tick still waits. The buffer reads as spaces from reset on
// through per-entry valid bits, so no clearing pass is needed.
module char_lcd_buffer_refresh_core
  import clbr_pkg::*;
#(
  parameter int CHARS = CHARS_DEF,
  parameter int LINES = LINES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [7:0] in_ch,
  input  logic [3:0] in_col,
  input  logic       in_row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_rs,
  output logic [3:0] out_nibble,
  output logic [5:0] out_wait_us,
  output logic       out_last
);

  localparam int CELLS  = CHARS * LINES;
  localparam int CELL_W = $clog2(CELLS);
  localparam int SCAN_W = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(CHARS);

  ctl_t ctl;
  sts_t sts;

  // Latched item.
  logic [1:0] func_r;
  logic [7:0] ch_r;
  logic [3:0] col_r;
  logic       row_r;

  // Cursor, scan position and buffer valid bits.
  logic [CELL_W-1:0] wp_r, wp_nxt;
  logic [SCAN_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [COL_W-1:0]  scan_col_r, scan_col_nxt;
  logic              scan_row_r, scan_row_nxt;
  logic [CELLS-1:0]  vld_r, vld_nxt;
  logic              rd_vld_r;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic       out_rs_r;
  logic [3:0] out_nibble_r;
  logic [5:0] out_wait_us_r;
  logic       out_last_r;

  logic              accept;
  logic              scan_end;
  logic              out_free;
  logic              out_load;
  logic              ram_we;
  logic              ram_re;
  logic [7:0]        ram_rdata;
  logic [7:0]        cur_byte;
  logic [7:0]        ddram_addr;
  logic              cur_ok;
  logic [CELL_W-1:0] cur_pos;
  logic              em_rs;
  logic [3:0]        em_nibble;
  logic [5:0]        em_wait;
  logic              em_last;

  assign accept   = in_valid && ctl.in_rdy;
  assign scan_end = (scan_idx_r == SCAN_W'(CELLS));
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (ctl.emit != EM_NONE) && out_free;
  assign ram_we   = (ctl.op == OP_WRITE);
  assign ram_re   = (ctl.op == OP_TICK) && !scan_end;

  assign sts = '{accept: accept, func: in_func, scan_end: scan_end,
                 row_start: (scan_col_r == '0), out_free: out_free};

  clbr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  clbr_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ch_r),
    .re    (ram_re),
    .raddr (scan_idx_r[CELL_W-1:0]),
    .rdata (ram_rdata)
  );

  // A buffer entry never written since reset or the last clear reads as a space.
  assign cur_byte   = rd_vld_r ? ram_rdata : SPACE_CHAR;
  assign ddram_addr = DDRAM_SET | (scan_row_r ? ROW_STRIDE : 8'h00);

  assign cur_ok  = (int'(row_r) < LINES) && (int'(col_r) < CHARS);
  assign cur_pos = CELL_W'(int'(row_r) * CHARS + int'(col_r));

  always_comb begin
    em_rs     = 1'b0;
    em_nibble = 4'h0;
    em_wait   = 6'd0;
    em_last   = 1'b0;
    case (ctl.emit)
      EM_ADDR_HI: em_nibble = ddram_addr[7:4];
      EM_ADDR_LO: begin
        em_nibble = ddram_addr[3:0];
        em_wait   = INSTR_WAIT;
      end
      EM_DATA_HI: begin
        em_rs     = 1'b1;
        em_nibble = cur_byte[7:4];
      end
      EM_DATA_LO: begin
        em_rs     = 1'b1;
        em_nibble = cur_byte[3:0];
        em_last   = 1'b1;
      end
      default: em_rs = 1'b0;
    endcase
  end

  always_comb begin
    wp_nxt        = wp_r;
    scan_idx_nxt  = scan_idx_r;
    scan_col_nxt  = scan_col_r;
    scan_row_nxt  = scan_row_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    case (ctl.op)
      OP_WRITE: begin
        vld_nxt[wp_r] = 1'b1;
        wp_nxt = (wp_r == CELL_W'(CELLS - 1)) ? '0 : wp_r + CELL_W'(1);
      end
      OP_SETCUR: begin
        if (cur_ok) begin
          wp_nxt = cur_pos;
        end
      end
      OP_CLEAR: begin
        vld_nxt = '0;
        wp_nxt  = '0;
      end
      OP_TICK: begin
        if (scan_end) begin
          scan_idx_nxt = '0;
          scan_col_nxt = '0;
          scan_row_nxt = 1'b0;
        end
      end
      default: wp_nxt = wp_r;
    endcase
    // The scan moves on once the final data nibble enters the output register.
    if (out_load && (ctl.emit == EM_DATA_LO)) begin
      scan_idx_nxt = scan_idx_r + SCAN_W'(1);
      if (scan_col_r == COL_W'(CHARS - 1)) begin
        scan_col_nxt = '0;
        scan_row_nxt = 1'b1;
      end else begin
        scan_col_nxt = scan_col_r + COL_W'(1);
      end
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      scan_idx_r  <= '0;
      scan_col_r  <= '0;
      scan_row_r  <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      scan_idx_r  <= scan_idx_nxt;
      scan_col_r  <= scan_col_nxt;
      scan_row_r  <= scan_row_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      ch_r   <= in_ch;
      col_r  <= in_col;
      row_r  <= in_row;
    end
    if (ram_re) begin
      rd_vld_r <= vld_r[scan_idx_r[CELL_W-1:0]];
    end
    if (out_load) begin
      out_rs_r      <= em_rs;
      out_nibble_r  <= em_nibble;
      out_wait_us_r <= em_wait;
      out_last_r    <= em_last;
    end
  end

  assign in_ready    = ctl.in_rdy;
  assign out_valid   = out_valid_r;
  assign out_rs      = out_rs_r;
  assign out_nibble  = out_nibble_r;
  assign out_wait_us = out_wait_us_r;
  assign out_last    = out_last_r;

  // The dispatch must land on the handler of the function that was latched.
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (ctl.op != OP_NONE) && (func_r == $past(in_func)))
    else $error("dispatch does not match the accepted function");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(wp_r) < CELLS)
    else $error("write cursor outside the buffer");

  a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !scan_end |-> int'(scan_idx_r) == int'(scan_row_r) * CHARS + int'(scan_col_r))
    else $error("scan index and row/column disagree");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (ctl.emit == EM_DATA_LO)) |=> ctl.in_rdy)
    else $error("sequencer did not return to fetch after the final nibble");

  a_wait_instr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_wait_us_r != 6'd0)) |-> !out_rs_r && !out_last_r)
    else $error("settle time on a data nibble");

endmodule

// File: hdl/clbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/clbr_seq.sv
// Microprogram sequencer: step counter, control-store lookup and branch logic.
module clbr_seq
  import clbr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output ctl_t ctl
);

  step_t step_r;
  step_t step_nxt;

  assign ctl = ucode(step_r);

  always_comb begin
    step_nxt = step_r;
    case (ctl.cond)
      C_GOTO: step_nxt = ctl.target;
      C_ACCEPT: begin
        if (sts.accept) begin
          step_nxt = ctl.target + step_t'(sts.func);
        end
      end
      C_SCAN: begin
        if (sts.scan_end) begin
          step_nxt = STEP_FETCH;
        end else if (sts.row_start) begin
          step_nxt = step_r + step_t'(1);
        end else begin
          step_nxt = ctl.target;
        end
      end
      C_OUT: begin
        if (sts.out_free) begin
          step_nxt = ctl.target;
        end
      end
      default: step_nxt = STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
